/* sv/srmt_pkg.sv */
// Shared types and constants for the shape region membership test block.
// No dependencies; the design modules refer to it by scoped names.
`default_nettype none

package srmt_pkg;

  // Table size and derived pointer width
  localparam int unsigned NUM_ENTRIES = 8;
  localparam int unsigned IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  // Width of one saturated Q.8 quotient
  localparam int unsigned Q_W = 24;

  // Request codes
  localparam logic [1:0] REQ_WRITE    = 2'd0;
  localparam logic [1:0] REQ_TEST_ALL = 2'd1;
  localparam logic [1:0] REQ_TEST_ONE = 2'd2;

  // Shape kinds; the two unused codes behave as a line
  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_LINE     = 3'd1;
  localparam logic [2:0] KIND_RECT     = 3'd2;
  localparam logic [2:0] KIND_CIRCLE   = 3'd3;
  localparam logic [2:0] KIND_PARABOLA = 3'd4;
  localparam logic [2:0] KIND_RHOMBUS  = 3'd5;

  // Shape constants: one half in Q.8, one quarter in Q.16
  localparam int Q_HALF      = 128;
  localparam int Q16_QUARTER = 16384;

  // One table entry as stored
  typedef struct packed {
    logic [2:0]         kind;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic [15:0]        scale_x;
    logic [15:0]        scale_y;
    logic               origin_side;
    logic               swap_axes;
  } entry_t;

endpackage

`default_nettype wire

/* sv/srmt_req_if.sv */
// Request channel: valid/ready handshake plus the request payload.
// Standalone; no package dependency.
`default_nettype none

interface srmt_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [2:0]         entry_index;
  logic [2:0]         shape_kind;
  logic signed [15:0] offset_x;
  logic signed [15:0] offset_y;
  logic [15:0]        scale_x;
  logic [15:0]        scale_y;
  logic               origin_side;
  logic               swap_axes;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;

  modport source (
    output valid, req_type, entry_index, shape_kind, offset_x, offset_y,
           scale_x, scale_y, origin_side, swap_axes, point_x, point_y,
    input  ready
  );

  modport sink (
    input  valid, req_type, entry_index, shape_kind, offset_x, offset_y,
           scale_x, scale_y, origin_side, swap_axes, point_x, point_y,
    output ready
  );
endinterface

`default_nettype wire

/* sv/srmt_res_if.sv */
// Result channel: valid/ready handshake plus the two result bits.
// Standalone; no package dependency.
`default_nettype none

interface srmt_res_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic entry_present;

  modport source (
    output valid, inside_res, entry_present,
    input  ready
  );

  modport sink (
    input  valid, inside_res, entry_present,
    output ready
  );
endinterface

`default_nettype wire

/* sv/shape_region_membership_test_top.sv */
// Shape region membership test, top level: entry table, sequencer, result reg.
// One item at a time; a loaded entry is run through two passes of the shared
// 24-step serial divider. Test-all visits each slot in turn and stops at the
// first miss. Synchronous rst clears the valid marks. Depends on srmt_pkg,
// both interfaces, srmt_div, srmt_shape.
`default_nettype none

module shape_region_membership_test_top (
  input  wire logic   clk,
  input  wire logic   rst,
  srmt_req_if.sink    req,
  srmt_res_if.source  res
);

  localparam int unsigned N  = srmt_pkg::NUM_ENTRIES;
  localparam int unsigned IW = srmt_pkg::IDX_W;
  localparam logic [IW-1:0] LAST = IW'(N - 1);

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_SCAN    = 10'b0000000010,
    ST_FETCH   = 10'b0000000100,
    ST_START_U = 10'b0000001000,
    ST_WAIT_U  = 10'b0000010000,
    ST_START_V = 10'b0000100000,
    ST_WAIT_V  = 10'b0001000000,
    ST_SHAPE   = 10'b0010000000,
    ST_EVAL    = 10'b0100000000,
    ST_RESP    = 10'b1000000000
  } state_t;

  state_t                          state;
  logic [N-1:0]                    entry_valid;
  srmt_pkg::entry_t                entry_mem [N];
  srmt_pkg::entry_t                rd_entry;
  logic [IW-1:0]                   ptr;
  logic                            mode_all;
  logic signed [15:0]              px;
  logic signed [15:0]              py;
  logic signed [srmt_pkg::Q_W-1:0] u_q;
  logic signed [srmt_pkg::Q_W-1:0] v_q;
  logic                            res_inside;
  logic                            res_present;
  logic                            out_valid;
  logic                            out_inside;
  logic                            out_present;

  logic                            accept;
  logic                            in_range;
  logic [IW-1:0]                   idx_ptr;
  logic                            res_free;
  logic                            sel_v;
  logic                            use_px;
  logic signed [16:0]              div_delta;
  logic [15:0]                     div_scale;
  logic                            div_start;
  logic                            div_done;
  logic signed [srmt_pkg::Q_W-1:0] div_quot;
  logic                            shape_en;
  logic                            hit;

  // Handshakes
  assign req.ready         = (state == ST_IDLE);
  assign accept            = req.valid && req.ready;
  assign in_range          = (32'(req.entry_index) < N);
  assign idx_ptr           = IW'(req.entry_index);
  assign res_free          = !out_valid || res.ready;
  assign res.valid         = out_valid;
  assign res.inside_res    = out_inside;
  assign res.entry_present = out_present;

  // Divider operands: swap flag and current pass pick the axis
  assign sel_v     = (state == ST_START_V);
  assign use_px    = rd_entry.swap_axes ^ sel_v;
  assign div_delta = use_px ?
    ({px[15], px} - {rd_entry.offset_y[15], rd_entry.offset_y}) :
    ({py[15], py} - {rd_entry.offset_x[15], rd_entry.offset_x});
  assign div_scale = sel_v ? rd_entry.scale_y : rd_entry.scale_x;
  assign div_start = (state == ST_START_U) || (state == ST_START_V);
  assign shape_en  = (state == ST_SHAPE);

  srmt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .delta (div_delta),
    .scale (div_scale),
    .done  (div_done),
    .quot  (div_quot)
  );

  srmt_shape u_shape (
    .clk         (clk),
    .en          (shape_en),
    .kind        (rd_entry.kind),
    .u           (u_q),
    .v           (v_q),
    .origin_side (rd_entry.origin_side),
    .hit         (hit)
  );

  // Entry table: one write port, registered read at the pointer
  always_ff @(posedge clk) begin
    if (accept && (req.req_type == srmt_pkg::REQ_WRITE) && in_range) begin
      entry_mem[idx_ptr] <= '{kind:        req.shape_kind,
                              offset_x:    req.offset_x,
                              offset_y:    req.offset_y,
                              scale_x:     req.scale_x,
                              scale_y:     req.scale_y,
                              origin_side: req.origin_side,
                              swap_axes:   req.swap_axes};
    end
    rd_entry <= entry_mem[ptr];
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_valid <= '0;
      out_valid   <= 1'b0;
    end else begin
      // Result register: set when leaving RESP, cleared on transfer
      if ((state == ST_RESP) && res_free) begin
        out_valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (req.req_type)
              srmt_pkg::REQ_WRITE: begin
                if (in_range) begin
                  entry_valid[idx_ptr] <= 1'b1;
                end
                state <= ST_RESP;
              end
              srmt_pkg::REQ_TEST_ALL: state <= ST_SCAN;
              srmt_pkg::REQ_TEST_ONE: begin
                state <= (in_range && entry_valid[idx_ptr]) ? ST_FETCH : ST_RESP;
              end
              default: state <= ST_RESP;
            endcase
          end
        end
        ST_SCAN: begin
          if (entry_valid[ptr]) begin
            state <= ST_FETCH;
          end else if (ptr == LAST) begin
            state <= ST_RESP;
          end
        end
        ST_FETCH:   state <= ST_START_U;
        ST_START_U: state <= ST_WAIT_U;
        ST_WAIT_U: begin
          if (div_done) begin
            state <= ST_START_V;
          end
        end
        ST_START_V: state <= ST_WAIT_V;
        ST_WAIT_V: begin
          if (div_done) begin
            state <= ST_SHAPE;
          end
        end
        ST_SHAPE: state <= ST_EVAL;
        ST_EVAL: begin
          state <= (!mode_all || !hit || (ptr == LAST)) ? ST_RESP : ST_SCAN;
        end
        ST_RESP: begin
          if (res_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          mode_all    <= (req.req_type == srmt_pkg::REQ_TEST_ALL);
          ptr         <= (req.req_type == srmt_pkg::REQ_TEST_ALL) ? '0 : idx_ptr;
          px          <= req.point_x;
          py          <= req.point_y;
          res_inside  <= (req.req_type == srmt_pkg::REQ_TEST_ALL);
          res_present <= (req.req_type == srmt_pkg::REQ_TEST_ONE) ?
                         (in_range && entry_valid[idx_ptr]) : 1'b1;
        end
      end
      ST_SCAN: begin
        if (!entry_valid[ptr] && (ptr != LAST)) begin
          ptr <= ptr + 1'b1;
        end
      end
      ST_WAIT_U: begin
        if (div_done) begin
          u_q <= div_quot;
        end
      end
      ST_WAIT_V: begin
        if (div_done) begin
          v_q <= div_quot;
        end
      end
      ST_EVAL: begin
        res_inside <= mode_all ? (res_inside && hit) : hit;
        if (mode_all && hit && (ptr != LAST)) begin
          ptr <= ptr + 1'b1;
        end
      end
      ST_RESP: begin
        if (res_free) begin
          out_inside  <= res_inside;
          out_present <= res_present;
        end
      end
      default: begin
      end
    endcase
  end

  // Checks
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_WAIT_U || state == ST_WAIT_V))
    else $error("divider finished outside a wait state");

  a_missing_outside: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.entry_present) |-> !res.inside_res)
    else $error("missing entry reported as inside");

  a_eval_after_shape: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL) |-> ($past(state) == ST_SHAPE))
    else $error("evaluation without a shape step");

endmodule

`default_nettype wire

/* sv/srmt_div.sv */
// Shared bit-serial divider: (delta * 256) / scale, truncated toward zero
// and saturated to a signed Q_W-bit value. Depends on srmt_pkg.
`default_nettype none

module srmt_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [16:0]                delta,
  input  wire logic [15:0]                       scale,
  output logic                                   done,
  output logic signed [srmt_pkg::Q_W-1:0]        quot
);

  localparam int unsigned CNT_W = $clog2(srmt_pkg::Q_W);
  localparam logic [srmt_pkg::Q_W-1:0] POS_LIM = {1'b0, {(srmt_pkg::Q_W-1){1'b1}}};
  localparam logic [srmt_pkg::Q_W-1:0] NEG_LIM = {1'b1, {(srmt_pkg::Q_W-1){1'b0}}};

  logic                      busy;
  logic                      fin;
  logic [CNT_W-1:0]          cnt;
  logic                      neg;
  logic                      zero;
  logic [srmt_pkg::Q_W-1:0]  num;
  logic [15:0]               rem;
  logic [15:0]               dvs;

  logic [16:0]               delta_mag;
  logic [16:0]               rem_sh;
  logic [16:0]               rem_diff;
  logic                      ge;
  logic [srmt_pkg::Q_W-1:0]  sat_mag;
  logic [srmt_pkg::Q_W-1:0]  quot_next;

  // Operand magnitude; |delta| never exceeds 16 bits
  assign delta_mag = delta[16] ? 17'(-delta) : 17'(delta);

  // One restoring step: shift in the next numerator bit, try subtract
  assign rem_sh   = {rem, num[srmt_pkg::Q_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs};
  assign ge       = (rem_sh >= {1'b0, dvs});

  // Sign and saturation; a zero numerator gives zero even for zero scale
  always_comb begin
    if (neg) begin
      sat_mag   = (num > NEG_LIM) ? NEG_LIM : num;
      quot_next = srmt_pkg::Q_W'(-sat_mag);
    end else begin
      sat_mag   = (num > POS_LIM) ? POS_LIM : num;
      quot_next = sat_mag;
    end
    if (zero) begin
      quot_next = '0;
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(srmt_pkg::Q_W - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: quotient bits shift into the numerator register
  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= delta[16];
      zero <= (delta == '0);
      num  <= {delta_mag[15:0], 8'b0};
      rem  <= '0;
      dvs  <= scale;
    end else if (busy) begin
      num <= {num[srmt_pkg::Q_W-2:0], ge};
      rem <= ge ? rem_diff[15:0] : rem_sh[15:0];
    end
    if (fin) begin
      quot <= quot_next;
    end
  end

endmodule

`default_nettype wire

/* sv/srmt_shape.sv */
// Shape evaluator: tests (u, v) against one shape kind and compares with
// the side holding the origin; result registered. Depends on srmt_pkg.
`default_nettype none

module srmt_shape (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [2:0]                        kind,
  input  wire logic signed [srmt_pkg::Q_W-1:0]   u,
  input  wire logic signed [srmt_pkg::Q_W-1:0]   v,
  input  wire logic                              origin_side,
  output logic                                   hit
);

  localparam logic signed [srmt_pkg::Q_W-1:0] HALF = srmt_pkg::Q_W'(srmt_pkg::Q_HALF);
  localparam logic signed [srmt_pkg::Q_W+1:0] HALF_W =
    (srmt_pkg::Q_W+2)'(srmt_pkg::Q_HALF);

  logic [srmt_pkg::Q_W-1:0]          au;
  logic [srmt_pkg::Q_W-1:0]          av;
  logic signed [srmt_pkg::Q_W+1:0]   u_w;
  logic signed [srmt_pkg::Q_W+1:0]   v_w;
  logic                              u_box;
  logic                              v_box;
  logic [13:0]                       sq_u;
  logic [13:0]                       sq_v;
  logic [14:0]                       sq_sum;
  logic [31:0]                       prod;
  logic                              in_rect;
  logic                              in_circle;
  logic                              in_parab;
  logic                              in_rhomb;
  logic                              in_line;
  logic                              shape_in;
  logic                              origin_in;

  assign au  = u[srmt_pkg::Q_W-1] ? srmt_pkg::Q_W'(-u) : u;
  assign av  = v[srmt_pkg::Q_W-1] ? srmt_pkg::Q_W'(-v) : v;
  assign u_w = {{2{u[srmt_pkg::Q_W-1]}}, u};
  assign v_w = {{2{v[srmt_pkg::Q_W-1]}}, v};

  // Box |u| < 0.5, |v| < 0.5
  assign u_box   = (u < HALF) && (u > -HALF);
  assign v_box   = (v < HALF) && (v > -HALF);
  assign in_rect = u_box && v_box;

  // Circle can only hit inside the box, where both magnitudes fit 7 bits
  assign sq_u      = au[6:0] * au[6:0];
  assign sq_v      = av[6:0] * av[6:0];
  assign sq_sum    = {1'b0, sq_u} + {1'b0, sq_v};
  assign in_circle = in_rect && (sq_sum < 15'(srmt_pkg::Q16_QUARTER));

  // Parabola v*256 < u*u; negative v or |u| >= 2^16 always hits
  assign prod     = au[15:0] * au[15:0];
  assign in_parab = v[srmt_pkg::Q_W-1] || (au[srmt_pkg::Q_W-1:16] != '0) ||
                    ({1'b0, v[22:0], 8'b0} < prod);

  // Rhombus: four half-planes
  assign in_rhomb = (v_w < u_w + HALF_W) && (v_w >= u_w - HALF_W) &&
                    (v_w < HALF_W - u_w) && (v_w >= -u_w - HALF_W);

  assign in_line = (v < u);

  always_comb begin
    case (kind)
      srmt_pkg::KIND_NONE:     shape_in = 1'b0;
      srmt_pkg::KIND_RECT:     shape_in = in_rect;
      srmt_pkg::KIND_CIRCLE:   shape_in = in_circle;
      srmt_pkg::KIND_PARABOLA: shape_in = in_parab;
      srmt_pkg::KIND_RHOMBUS:  shape_in = in_rhomb;
      default:                 shape_in = in_line;
    endcase
  end

  // Shapes that contain (0, 0)
  assign origin_in = (kind == srmt_pkg::KIND_RECT) || (kind == srmt_pkg::KIND_CIRCLE) ||
                     (kind == srmt_pkg::KIND_RHOMBUS);

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= (shape_in == (origin_in == origin_side));
    end
  end

endmodule

`default_nettype wire
